[rtl/tshc_pkg.sv]
// shared types and constants of the turn signal and headlight controller
`timescale 1ns / 1ps
`default_nettype none

package tshc_pkg;

  // counter widths
  localparam int StableCountWidth = 8;
  localparam int FlashCountWidth  = 16;

  // register widths
  localparam int DebounceTimeWidth  = 8;
  localparam int BlinkIntervalWidth = 16;
  localparam int CfgDataWidth =
    (DebounceTimeWidth > BlinkIntervalWidth) ? DebounceTimeWidth : BlinkIntervalWidth;
  localparam int CfgIndexWidth = 1;

  // compare widths, wide enough for both operands
  localparam int DbCmpWidth =
    (StableCountWidth > DebounceTimeWidth) ? StableCountWidth : DebounceTimeWidth;
  localparam int FlashCmpWidth =
    (FlashCountWidth > BlinkIntervalWidth) ? FlashCountWidth : BlinkIntervalWidth;

  // register reset values
  localparam logic [DebounceTimeWidth-1:0]  DebounceTimeReset  = DebounceTimeWidth'(50);
  localparam logic [BlinkIntervalWidth-1:0] BlinkIntervalReset = BlinkIntervalWidth'(500);

  // register indexes
  localparam logic [CfgIndexWidth-1:0] RegDebounceTime  = CfgIndexWidth'(0);
  localparam logic [CfgIndexWidth-1:0] RegBlinkInterval = CfgIndexWidth'(1);

  typedef struct packed {
    logic high_switch_n;
    logic low_switch_n;
    logic left_button_n;
    logic right_button_n;
  } in_item_t;

  typedef struct packed {
    logic high_relay;
    logic low_relay;
    logic left_relay;
    logic right_relay;
    logic left_enabled;
    logic right_enabled;
    logic high_requested;
    logic low_requested;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/tshc_if.sv]
// valid/ready channel interfaces for input ticks and result items
`timescale 1ns / 1ps
`default_nettype none

interface tshc_in_if;
  logic               valid;
  logic               ready;
  tshc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tshc_out_if;
  logic                valid;
  logic                ready;
  tshc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/tshc_debounce.sv]
// turn button debouncer with saturating stable counter and press edge detect
`timescale 1ns / 1ps
`default_nettype none

module tshc_debounce (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      step,
  input  wire logic                                      level_n,
  input  wire logic [tshc_pkg::DebounceTimeWidth-1:0]    debounce_time,
  output logic                                           press_edge
);

  logic                                    last_level_r, last_level_nxt;
  logic [tshc_pkg::StableCountWidth-1:0]   count_r, count_nxt;
  logic                                    was_pressed_r, was_pressed_nxt;
  logic                                    now_pressed;
  logic                                    held;

  always_comb begin
    now_pressed = ~level_n;
    if (now_pressed != last_level_r) begin
      count_nxt = '0;
    end else if (count_r != '1) begin
      count_nxt = count_r + 1'b1;
    end else begin
      count_nxt = count_r;
    end
    held = now_pressed &&
           (tshc_pkg::DbCmpWidth'(count_nxt) > tshc_pkg::DbCmpWidth'(debounce_time));
    press_edge      = held && !was_pressed_r;
    last_level_nxt  = now_pressed;
    was_pressed_nxt = held;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r  <= 1'b0;
      count_r       <= '0;
      was_pressed_r <= 1'b0;
    end else if (step) begin
      last_level_r  <= last_level_nxt;
      count_r       <= count_nxt;
      was_pressed_r <= was_pressed_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/turn_signal_and_headlight_controller.sv]
// top level: headlight relays, debounced turn toggles and shared flash timer
// path: a tick passes the input register, then the result register, before its result is valid
// throughput: one tick per cycle while out_ch.ready is high; a new tick is taken while
//   the result register drains
// stalls: ready drops only when the input and result registers are both full and out_ch.ready is low
// reset: rst_n synchronous active low; counters, flags and phase clear, registers
//   return to debounce_time 50 and blink_interval 500
`timescale 1ns / 1ps
`default_nettype none

module turn_signal_and_headlight_controller (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  tshc_in_if.sink                                     in_ch,
  tshc_out_if.source                                  out_ch,
  input  wire logic                                   cfg_we,
  input  wire logic [tshc_pkg::CfgIndexWidth-1:0]     cfg_index,
  input  wire logic [tshc_pkg::CfgDataWidth-1:0]      cfg_wdata
);

  // configuration registers
  logic [tshc_pkg::DebounceTimeWidth-1:0]  debounce_time_r;
  logic [tshc_pkg::BlinkIntervalWidth-1:0] blink_interval_r;

  // input register
  logic               in_valid_r;
  tshc_pkg::in_item_t in_data_r;

  // result register
  logic                out_valid_r;
  tshc_pkg::out_item_t out_data_r, out_data_nxt;

  // blinker and flash state
  logic                                   left_active_r, left_active_nxt;
  logic                                   right_active_r, right_active_nxt;
  logic                                   flash_phase_r, flash_phase_nxt;
  logic [tshc_pkg::FlashCountWidth-1:0]   flash_elapsed_r, flash_elapsed_nxt;

  logic advance;    // the held tick moves into the result register
  logic left_edge;
  logic right_edge;
  logic restart;
  logic high_req;
  logic low_req;

  // the held tick is worked on as it leaves the input register
  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_time_r  <= tshc_pkg::DebounceTimeReset;
      blink_interval_r <= tshc_pkg::BlinkIntervalReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tshc_pkg::RegDebounceTime:
          debounce_time_r <= cfg_wdata[tshc_pkg::DebounceTimeWidth-1:0];
        tshc_pkg::RegBlinkInterval:
          blink_interval_r <= cfg_wdata[tshc_pkg::BlinkIntervalWidth-1:0];
        default: ;
      endcase
    end
  end

  // one debouncer per turn button, stepped once per tick
  tshc_debounce u_left_db (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .level_n       (in_data_r.left_button_n),
    .debounce_time (debounce_time_r),
    .press_edge    (left_edge)
  );

  tshc_debounce u_right_db (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .level_n       (in_data_r.right_button_n),
    .debounce_time (debounce_time_r),
    .press_edge    (right_edge)
  );

  always_comb begin
    high_req = ~in_data_r.high_switch_n;
    low_req  = ~in_data_r.low_switch_n;

    // edges toggle their side, any edge restarts the shared phase
    left_active_nxt  = left_active_r ^ left_edge;
    right_active_nxt = right_active_r ^ right_edge;
    restart          = left_edge || right_edge;

    // saturating flash timer
    if (flash_elapsed_r != '1) begin
      flash_elapsed_nxt = flash_elapsed_r + 1'b1;
    end else begin
      flash_elapsed_nxt = flash_elapsed_r;
    end
    flash_phase_nxt = flash_phase_r;
    if (restart) begin
      flash_elapsed_nxt = '0;
      flash_phase_nxt   = 1'b0;
    end

    // interval reached: toggle phase; on a restart tick only when blink_interval is zero
    if (tshc_pkg::FlashCmpWidth'(flash_elapsed_nxt) >=
        tshc_pkg::FlashCmpWidth'(blink_interval_r)) begin
      flash_elapsed_nxt = '0;
      flash_phase_nxt   = ~flash_phase_nxt;
    end

    // high beam wins over low beam
    out_data_nxt.high_relay     = high_req;
    out_data_nxt.low_relay      = !high_req && low_req;
    out_data_nxt.left_relay     = left_active_nxt && flash_phase_nxt;
    out_data_nxt.right_relay    = right_active_nxt && flash_phase_nxt;
    out_data_nxt.left_enabled   = left_active_nxt;
    out_data_nxt.right_enabled  = right_active_nxt;
    out_data_nxt.high_requested = high_req;
    out_data_nxt.low_requested  = low_req;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
    end
    if (in_ch.valid && in_ch.ready) begin
      in_data_r <= in_ch.data;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r     <= 1'b0;
      left_active_r   <= 1'b0;
      right_active_r  <= 1'b0;
      flash_phase_r   <= 1'b0;
      flash_elapsed_r <= '0;
    end else begin
      if (advance) begin
        out_valid_r     <= 1'b1;
        left_active_r   <= left_active_nxt;
        right_active_r  <= right_active_nxt;
        flash_phase_r   <= flash_phase_nxt;
        flash_elapsed_r <= flash_elapsed_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire
